/* hdl/rpm_pkg.sv */
package rpm_pkg;

  // Field widths of one item
  localparam int VAL_W   = 30;
  localparam int INDEX_W = 11;
  localparam int CFG_W   = 11;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int PW          = ADDR_W + 1;
  localparam int CW          = (PW > INDEX_W) ? PW : INDEX_W;
  localparam int MCNT_W      = $clog2(VAL_W);

  localparam logic [VAL_W-1:0] PRIME = VAL_W'(1000000007);

  // Item actions
  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_S_RD, ST_S_OLD, ST_S_INV, ST_S_FST, ST_S_FMW,
    ST_W_RD, ST_W_MST, ST_W_MW,
    ST_Q_RD, ST_Q_MST, ST_Q_MW, ST_Q_CHK, ST_Q_INV, ST_Q_FMW
  } state_t;

  // Operand pairs of the modular multiplier
  typedef enum logic [1:0] {
    MS_FACT,   // inverse of old value times new value, zeros taken as one
    MS_NODE,   // tree node times update factor
    MS_QACC,   // prefix accumulator times tree node
    MS_FINAL   // upper prefix times inverse of lower prefix
  } mul_sel_t;

  typedef enum logic {
    IS_OLD,
    IS_PREFIX
  } inv_sel_t;

  typedef struct packed {
    logic     clr_step;
    logic     accept;
    logic     ev_wr;
    logic     set_old;
    logic     f_one;
    logic     f_inv;
    logic     f_mul;
    logic     walk_wr;
    logic     pos_up;
    logic     q_acc;
    logic     pa_load;
    logic     phase_end;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     inv_start;
    inv_sel_t inv_sel;
    logic     emit_zero;
    logic     emit_mul;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_ok;
    logic old_nz;
    logic pos_top;
    logic pos_zero;
    logic mul_done;
    logic inv_done;
    logic cnt_ok;
  } stat_t;

endpackage

/* hdl/range_product_mod_prime_table.sv */
// Range product table modulo 1000000007 over up to 1024 elements, indexed from one.
// An item is taken when start is high and busy is low; a set item gives no result,
// a query gives one, shown on out_range_product for the single cycle out_valid is
// high, and the receiver must take it then. Items with an index of zero or above
// element_count or 1024 are dropped. After reset the block sweeps all 1024 entries
// of its three tables with busy high. Items are handled one at a time; a set walks
// up to eleven tree nodes, a query up to twenty, each node taking one run of the
// bit-serial modular multiplier, plus at most one run of the binary inverse unit.
// A query's result appears in the cycle after its last busy cycle.
module range_product_mod_prime_table
  import rpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [INDEX_W-1:0] in_left_index,
  input  logic [INDEX_W-1:0] in_right_index,
  input  logic [VAL_W-1:0]   in_new_value,
  output logic               out_valid,
  output logic [VAL_W-1:0]   out_range_product,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CFG_W-1:0] count_r, count_nxt;
  logic [CW-1:0]    limit;
  cmd_t             cmd;
  stat_t            stat;

  // Configuration register
  always_comb begin
    count_nxt = count_r;
    if (psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT)) begin
      count_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CFG_W'(1024);
    end else begin
      count_r <= count_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? 32'(count_r) : '0;
  assign limit  = (CW'(count_r) < CW'(TABLE_DEPTH)) ? CW'(count_r) : CW'(TABLE_DEPTH);

  rpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  rpm_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .limit             (limit),
    .in_action         (in_action),
    .in_left_index     (in_left_index),
    .in_right_index    (in_right_index),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_range_product (out_range_product)
  );

endmodule

/* hdl/rpm_mulmod.sv */
module rpm_mulmod
  import rpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic             done,
  output logic [VAL_W-1:0] y
);

  logic [VAL_W-1:0]  a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt, done_r, done_nxt;
  logic [VAL_W:0]    dbl, dbl_red, sum;
  logic [VAL_W-1:0]  step;

  // One multiplier bit a cycle, most significant first: acc = 2*acc + bit*a mod p
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
    sum     = dbl_red + {1'b0, (b_r[VAL_W-1] ? a_r : '0)};
    step    = (sum >= {1'b0, PRIME}) ? VAL_W'(sum - {1'b0, PRIME}) : VAL_W'(sum);
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = a;
      b_nxt   = b;
      acc_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = step;
      b_nxt   = {b_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r + MCNT_W'(1);
      if (cnt_r == MCNT_W'(VAL_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign y    = acc_r;

endmodule

/* hdl/rpm_invmod.sv */
module rpm_invmod
  import rpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  output logic             done,
  output logic [VAL_W-1:0] y
);

  logic [VAL_W-1:0] u_r, u_nxt, v_r, v_nxt, x1_r, x1_nxt, x2_r, x2_nxt, y_r, y_nxt;
  logic             run_r, run_nxt, done_r, done_nxt;
  logic [VAL_W:0]   x1_sum, x2_sum, d12, d21;

  // Binary extended GCD against the prime: one halving or subtraction a cycle
  always_comb begin
    x1_sum = {1'b0, x1_r} + {1'b0, PRIME};
    x2_sum = {1'b0, x2_r} + {1'b0, PRIME};
    d12    = {1'b0, x1_r} - {1'b0, x2_r};
    d21    = {1'b0, x2_r} - {1'b0, x1_r};
  end

  always_comb begin
    u_nxt    = u_r;
    v_nxt    = v_r;
    x1_nxt   = x1_r;
    x2_nxt   = x2_r;
    y_nxt    = y_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      u_nxt   = a;
      v_nxt   = PRIME;
      x1_nxt  = VAL_W'(1);
      x2_nxt  = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      priority if (u_r == VAL_W'(1)) begin
        y_nxt    = x1_r;
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else if (v_r == VAL_W'(1)) begin
        y_nxt    = x2_r;
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else if (!u_r[0]) begin
        u_nxt  = u_r >> 1;
        x1_nxt = x1_r[0] ? x1_sum[VAL_W:1] : (x1_r >> 1);
      end else if (!v_r[0]) begin
        v_nxt  = v_r >> 1;
        x2_nxt = x2_r[0] ? x2_sum[VAL_W:1] : (x2_r >> 1);
      end else if (u_r >= v_r) begin
        u_nxt  = u_r - v_r;
        x1_nxt = d12[VAL_W] ? VAL_W'(d12 + {1'b0, PRIME}) : VAL_W'(d12);
      end else begin
        v_nxt  = v_r - u_r;
        x2_nxt = d21[VAL_W] ? VAL_W'(d21 + {1'b0, PRIME}) : VAL_W'(d21);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    u_r  <= u_nxt;
    v_r  <= v_nxt;
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    y_r  <= y_nxt;
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

/* hdl/rpm_datapath.sv */
module rpm_datapath
  import rpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [CW-1:0]      limit,
  input  logic               in_action,
  input  logic [INDEX_W-1:0] in_left_index,
  input  logic [INDEX_W-1:0] in_right_index,
  input  logic [VAL_W-1:0]   in_new_value,
  output logic               out_valid,
  output logic [VAL_W-1:0]   out_range_product
);

  // Tables
  logic [VAL_W-1:0] ev_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] pt_mem [TABLE_DEPTH];
  logic [PW-1:0]    ct_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] ev_q, pt_q;
  logic [PW-1:0]    ct_q;

  logic [ADDR_W-1:0] clr_r, clr_nxt, mem_addr;
  logic [PW-1:0]     pos_r, pos_nxt, lo_r, lo_nxt, hi_r, hi_nxt, ca_r, ca_nxt, hc_r, hc_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt, f_r, f_nxt, pa_r, pa_nxt, hp_r, hp_nxt;
  logic              val_nz_r, val_nz_nxt, old_nz_r, old_nz_nxt;
  logic              ov_r, ov_nxt;
  logic [VAL_W-1:0]  op_r, op_nxt;

  logic [CW-1:0]    l_ext, r_ext;
  logic             l_ok, r_ok, swap;
  logic [VAL_W-1:0] val_red;
  logic [PW-1:0]    low_bit, ct_wdata;
  logic [PW:0]      pos_up_sum;
  logic [VAL_W-1:0] mul_a, mul_b, mul_y, inv_a, inv_y;
  logic             mul_done, inv_done;

  // Input checks on the item being offered
  always_comb begin
    l_ext   = CW'(in_left_index);
    r_ext   = CW'(in_right_index);
    l_ok    = (l_ext != '0) && (l_ext <= limit);
    r_ok    = (r_ext != '0) && (r_ext <= limit);
    swap    = (in_action == ACT_QUERY) && (l_ext > r_ext);
    val_red = (in_new_value >= PRIME) ? in_new_value - PRIME : in_new_value;
  end

  // Walk pointer arithmetic
  always_comb begin
    low_bit    = pos_r & (~pos_r + PW'(1));
    pos_up_sum = {1'b0, pos_r} + {1'b0, low_bit};
    mem_addr   = cmd.clr_step ? clr_r : ADDR_W'(pos_r - PW'(1));
    ct_wdata   = ct_q + PW'(val_nz_r) - PW'(old_nz_r);
  end

  // Memories: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step || cmd.ev_wr) begin
      ev_mem[mem_addr] <= cmd.clr_step ? '0 : val_r;
    end
    if (cmd.clr_step || cmd.walk_wr) begin
      pt_mem[mem_addr] <= cmd.clr_step ? VAL_W'(1) : mul_y;
      ct_mem[mem_addr] <= cmd.clr_step ? '0 : ct_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ev_q <= ev_mem[mem_addr];
    pt_q <= pt_mem[mem_addr];
    ct_q <= ct_mem[mem_addr];
  end

  // Arithmetic units and their operand selection
  always_comb begin
    unique case (cmd.mul_sel)
      MS_FACT:  begin mul_a = f_r;  mul_b = val_nz_r ? val_r : VAL_W'(1); end
      MS_NODE:  begin mul_a = pt_q; mul_b = f_r;   end
      MS_QACC:  begin mul_a = pa_r; mul_b = pt_q;  end
      MS_FINAL: begin mul_a = hp_r; mul_b = inv_y; end
      default:  begin mul_a = f_r;  mul_b = f_r;   end
    endcase
    inv_a = (cmd.inv_sel == IS_OLD) ? ev_q : pa_r;
  end

  rpm_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .y     (mul_y)
  );

  rpm_invmod u_inv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.inv_start),
    .a     (inv_a),
    .done  (inv_done),
    .y     (inv_y)
  );

  // Working registers
  always_comb begin
    clr_nxt    = clr_r;
    pos_nxt    = pos_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    val_nxt    = val_r;
    val_nz_nxt = val_nz_r;
    old_nz_nxt = old_nz_r;
    f_nxt      = f_r;
    pa_nxt     = pa_r;
    ca_nxt     = ca_r;
    hp_nxt     = hp_r;
    hc_nxt     = hc_r;
    ov_nxt     = 1'b0;
    op_nxt     = op_r;
    if (cmd.clr_step) clr_nxt = clr_r + ADDR_W'(1);
    if (cmd.accept) begin
      lo_nxt     = swap ? PW'(r_ext) : PW'(l_ext);
      hi_nxt     = swap ? PW'(l_ext) : PW'(r_ext);
      pos_nxt    = (in_action == ACT_QUERY) ? (swap ? PW'(l_ext) : PW'(r_ext)) : PW'(l_ext);
      val_nxt    = val_red;
      val_nz_nxt = (val_red != '0);
      pa_nxt     = VAL_W'(1);
      ca_nxt     = '0;
    end
    if (cmd.set_old) old_nz_nxt = (ev_q != '0);
    if (cmd.f_one) f_nxt = VAL_W'(1);
    if (cmd.f_inv) f_nxt = inv_y;
    if (cmd.f_mul) f_nxt = mul_y;
    if (cmd.pos_up) pos_nxt = PW'(pos_up_sum);
    if (cmd.q_acc) ca_nxt = ca_r + ct_q;
    if (cmd.pa_load) begin
      pa_nxt  = mul_y;
      pos_nxt = pos_r - low_bit;
    end
    if (cmd.phase_end) begin
      hp_nxt  = pa_r;
      hc_nxt  = ca_r;
      pa_nxt  = VAL_W'(1);
      ca_nxt  = '0;
      pos_nxt = lo_r - PW'(1);
    end
    if (cmd.emit_zero) begin
      ov_nxt = 1'b1;
      op_nxt = '0;
    end
    if (cmd.emit_mul) begin
      ov_nxt = 1'b1;
      op_nxt = mul_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
    pos_r    <= pos_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    val_r    <= val_nxt;
    val_nz_r <= val_nz_nxt;
    old_nz_r <= old_nz_nxt;
    f_r      <= f_nxt;
    pa_r     <= pa_nxt;
    ca_r     <= ca_nxt;
    hp_r     <= hp_nxt;
    hc_r     <= hc_nxt;
    op_r     <= op_nxt;
  end

  // Status to the controller
  always_comb begin
    stat.clr_last = (clr_r == ADDR_W'(TABLE_DEPTH - 1));
    stat.in_ok    = (in_action == ACT_QUERY) ? (l_ok && r_ok) : l_ok;
    stat.old_nz   = (ev_q != '0);
    stat.pos_top  = (pos_up_sum > (PW + 1)'(TABLE_DEPTH));
    stat.pos_zero = (pos_r == '0);
    stat.mul_done = mul_done;
    stat.inv_done = inv_done;
    stat.cnt_ok   = ((hc_r - ca_r) == (hi_r - lo_r + PW'(1)));
  end

  assign out_valid         = ov_r;
  assign out_range_product = op_r;

`ifndef SYNTH
  a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_zero && cmd.emit_mul))
    else $error("two results in one cycle");
  a_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (mul_y < PRIME))
    else $error("product not reduced");
  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    inv_done |-> ((inv_y < PRIME) && (inv_y != '0)))
    else $error("inverse out of range");
  a_walk_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_wr |-> ((pos_r != '0) && (pos_r <= PW'(TABLE_DEPTH))))
    else $error("tree write outside table");
`endif

endmodule

/* hdl/rpm_ctrl.sv */
module rpm_ctrl
  import rpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  in_action,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        phase_nxt = 1'b0;
        if (start && stat.in_ok) begin
          state_nxt = (in_action == ACT_QUERY) ? ST_Q_RD : ST_S_RD;
        end
      end
      ST_S_RD:  state_nxt = ST_S_OLD;
      ST_S_OLD: state_nxt = stat.old_nz ? ST_S_INV : ST_S_FST;
      ST_S_INV: if (stat.inv_done) state_nxt = ST_S_FST;
      ST_S_FST: state_nxt = ST_S_FMW;
      ST_S_FMW: if (stat.mul_done) state_nxt = ST_W_RD;
      ST_W_RD:  state_nxt = ST_W_MST;
      ST_W_MST: state_nxt = ST_W_MW;
      ST_W_MW: begin
        if (stat.mul_done) state_nxt = stat.pos_top ? ST_IDLE : ST_W_RD;
      end
      ST_Q_RD: begin
        if (stat.pos_zero) begin
          if (phase_r) state_nxt = ST_Q_CHK;
          else phase_nxt = 1'b1;
        end else begin
          state_nxt = ST_Q_MST;
        end
      end
      ST_Q_MST: state_nxt = ST_Q_MW;
      ST_Q_MW:  if (stat.mul_done) state_nxt = ST_Q_RD;
      ST_Q_CHK: state_nxt = stat.cnt_ok ? ST_Q_INV : ST_IDLE;
      ST_Q_INV: if (stat.inv_done) state_nxt = ST_Q_FMW;
      ST_Q_FMW: if (stat.mul_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MS_FACT;
    cmd.inv_sel = IS_OLD;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE:  cmd.accept = start;
      ST_S_RD:  ;
      ST_S_OLD: begin
        cmd.ev_wr   = 1'b1;
        cmd.set_old = 1'b1;
        cmd.inv_start = stat.old_nz;
        cmd.f_one   = !stat.old_nz;
      end
      ST_S_INV: cmd.f_inv = stat.inv_done;
      ST_S_FST: cmd.mul_start = 1'b1;
      ST_S_FMW: cmd.f_mul = stat.mul_done;
      ST_W_RD:  ;
      ST_W_MST: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_NODE;
      end
      ST_W_MW: begin
        cmd.mul_sel = MS_NODE;
        cmd.walk_wr = stat.mul_done;
        cmd.pos_up  = stat.mul_done;
      end
      ST_Q_RD: cmd.phase_end = stat.pos_zero && !phase_r;
      ST_Q_MST: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_QACC;
        cmd.q_acc     = 1'b1;
      end
      ST_Q_MW: begin
        cmd.mul_sel = MS_QACC;
        cmd.pa_load = stat.mul_done;
      end
      ST_Q_CHK: begin
        cmd.inv_sel   = IS_PREFIX;
        cmd.inv_start = stat.cnt_ok;
        cmd.emit_zero = !stat.cnt_ok;
      end
      ST_Q_INV: begin
        cmd.inv_sel   = IS_PREFIX;
        cmd.mul_sel   = MS_FINAL;
        cmd.mul_start = stat.inv_done;
      end
      ST_Q_FMW: begin
        cmd.mul_sel  = MS_FINAL;
        cmd.emit_mul = stat.mul_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
